[hdl/slwt_pkg.sv]
// Package for the source liveness watch table.
// Types, sizes and register codes shared by the interfaces and all modules.
package slwt_pkg;

  // table size and derived widths
  localparam int ENTRIES = 16;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // field widths
  localparam int KEY_W  = 64;
  localparam int TIME_W = 32;
  localparam int WIN_W  = 17;
  localparam int REC_W  = 5;
  localparam int CFG_W  = 32;

  // reset values of the configuration registers
  localparam logic [WIN_W-1:0]  FAIL_WINDOW_RST = WIN_W'(3600);
  localparam logic [TIME_W-1:0] MIN_VALID_RST   = TIME_W'(32'd1609459200);

  // request kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_SCAN   = 1'b1;

  // result kinds
  localparam logic EV_DOWN    = 1'b0;
  localparam logic EV_SUMMARY = 1'b1;

  // configuration register indexes
  typedef enum logic {
    CFG_FAIL_WINDOW = 1'b0,
    CFG_MIN_VALID   = 1'b1
  } cfg_idx_t;

  // one table entry, held by one cell
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] last_success;
    logic [TIME_W-1:0] last_attempt;
    logic              alert;
  } entry_t;

  // request being worked on
  typedef struct packed {
    logic              kind;
    logic [KEY_W-1:0]  key;
    logic              ok;
    logic [TIME_W-1:0] now;
  } op_t;

  // status from the head evaluator to the control
  typedef struct packed {
    logic hit;      // report matched or entered this entry
    logic fresh;    // report entered a new entry
    logic emit;     // scan found this source newly down
    logic recover;  // scan cleared this source's flag
  } eval_st_t;

endpackage

[hdl/slwt_ifs.sv]
// Channel interfaces of the source liveness watch table.
// Depends on slwt_pkg for field widths.
interface slwt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [slwt_pkg::KEY_W-1:0]   source_key;
  logic                         success;
  logic [slwt_pkg::TIME_W-1:0]  now_seconds;
  modport source (output valid, kind, source_key, success, now_seconds, input ready);
  modport sink   (input valid, kind, source_key, success, now_seconds, output ready);
endinterface

interface slwt_out_if;
  logic                         valid;
  logic                         ready;
  logic                         event_res;
  logic [slwt_pkg::KEY_W-1:0]   down_key;
  logic [slwt_pkg::REC_W-1:0]   recovered_count;
  logic                         any_news;
  logic                         last;
  modport source (output valid, event_res, down_key, recovered_count, any_news, last,
                  input ready);
  modport sink   (input valid, event_res, down_key, recovered_count, any_news, last,
                  output ready);
endinterface

interface slwt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic                         index;
  logic [slwt_pkg::CFG_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/slwt_cell.sv]
// One storage cell of the rotating entry ring.
// Depends on slwt_pkg for the entry type.
module slwt_cell (
  input  logic             clk,
  input  logic             shift,
  input  slwt_pkg::entry_t ent_in,
  output slwt_pkg::entry_t ent_out
);
  import slwt_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // take the neighbor's entry when the ring advances
  always_comb begin
    ent_nxt = shift ? ent_in : ent_r;
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent_out = ent_r;
endmodule

[hdl/slwt_eval.sv]
// Head evaluator: updates the entry leaving the front of the ring.
// Depends on slwt_pkg for the entry, request and status types.
module slwt_eval (
  input  slwt_pkg::entry_t              ent_in,
  input  slwt_pkg::op_t                 op,
  input  logic [slwt_pkg::CNT_W-1:0]    step,
  input  logic [slwt_pkg::CNT_W-1:0]    used,
  input  logic                          hit_seen,
  input  logic [slwt_pkg::WIN_W-1:0]    fail_window,
  output slwt_pkg::entry_t              ent_out,
  output slwt_pkg::eval_st_t            st
);
  import slwt_pkg::*;

  logic               active;
  logic               match;
  logic               fresh;
  logic signed [TIME_W:0] since_try;
  logic signed [TIME_W:0] since_ok;
  logic signed [TIME_W:0] win;
  logic               recent;
  logic               down;

  // signed time differences, one bit wider than the time fields
  assign since_try = $signed({1'b0, op.now}) - $signed({1'b0, ent_in.last_attempt});
  assign since_ok  = $signed({1'b0, op.now}) - $signed({1'b0, ent_in.last_success});
  assign win       = $signed({{(TIME_W + 1 - WIN_W){1'b0}}, fail_window});
  assign recent    = since_try < win;
  assign down      = since_ok > win;

  assign active = step < used;
  assign match  = active && !hit_seen && (ent_in.key == op.key);
  assign fresh  = (step == used) && !hit_seen;

  always_comb begin
    ent_out    = ent_in;
    st         = '0;
    if (op.kind == KIND_REPORT) begin
      // report: update a known key, or enter a new one at the first free slot
      if (match) begin
        st.hit = 1'b1;
        ent_out.last_attempt = op.now;
        if (op.ok) begin
          ent_out.last_success = op.now;
          ent_out.alert        = 1'b0;
        end
      end else if (fresh) begin
        st.hit   = 1'b1;
        st.fresh = 1'b1;
        ent_out.key          = op.key;
        ent_out.last_success = op.now;
        ent_out.last_attempt = op.now;
        ent_out.alert        = 1'b0;
      end
    end else if (active) begin
      // scan: flag newly down sources, clear recovered ones
      if (down && recent && !ent_in.alert) begin
        st.emit       = 1'b1;
        ent_out.alert = 1'b1;
      end else if (!down && ent_in.alert) begin
        st.recover    = 1'b1;
        ent_out.alert = 1'b0;
      end
    end
  end
endmodule

[hdl/source_liveness_watch_table.sv]
// Top level of the source liveness watch table: control, configuration and entry ring.
// Depends on slwt_pkg, slwt_ifs, slwt_cell and slwt_eval.
//
//   channel  dir  moves                                     handshake
//   in_ch    in   kind, source_key, success, now_seconds    valid/ready
//   out_ch   out  event_res, down_key, recovered_count,     valid/ready
//                 any_news, last
//   cfg_ch   in   index, data                               valid/ready
//
// Entries sit in a ring of ENTRIES cells that rotates one place a cycle during
// a request unless held; the front entry is checked and updated as it wraps to
// the back. A report walks the ring once; a scan also issues a summary and may
// be held by output stalls. An invalid-time request is taken and does nothing.
// Reset clears the fill count and control; entry contents are not reset.
// A scan holds the ring while a down result waits for the output register.
module source_liveness_watch_table (
  input  logic        clk,
  input  logic        rst_n,
  slwt_in_if.sink     in_ch,
  slwt_out_if.source  out_ch,
  slwt_cfg_if.sink    cfg_ch
);
  import slwt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_SUM  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [CNT_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic              hit_r, hit_nxt;
  logic [REC_W-1:0]  nrec_r, nrec_nxt;
  logic              news_r, news_nxt;
  logic [WIN_W-1:0]  fail_window_r;
  logic [TIME_W-1:0] min_valid_r;

  logic              out_valid_r, out_valid_nxt;
  logic              out_ev_r, out_ev_nxt;
  logic [KEY_W-1:0]  out_key_r, out_key_nxt;
  logic [REC_W-1:0]  out_rec_r, out_rec_nxt;
  logic              out_news_r, out_news_nxt;
  logic              out_last_r, out_last_nxt;

  entry_t            ring [ENTRIES];
  entry_t            head_upd;
  eval_st_t          est;
  logic              shift;
  logic              out_free;
  logic              in_acc;
  logic              time_ok;

  // configuration writes, accepted at any time
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_window_r <= FAIL_WINDOW_RST;
      min_valid_r   <= MIN_VALID_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_FAIL_WINDOW: fail_window_r <= cfg_ch.data[WIN_W-1:0];
        CFG_MIN_VALID:   min_valid_r   <= cfg_ch.data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // entry ring
  for (genvar k = 0; k < ENTRIES; k++) begin : g_ring
    if (k == ENTRIES - 1) begin : g_tail
      slwt_cell u_cell (.clk(clk), .shift(shift), .ent_in(head_upd), .ent_out(ring[k]));
    end else begin : g_mid
      slwt_cell u_cell (.clk(clk), .shift(shift), .ent_in(ring[k+1]), .ent_out(ring[k]));
    end
  end

  slwt_eval u_eval (
    .ent_in      (ring[0]),
    .op          (op_r),
    .step        (step_r),
    .used        (used_r),
    .hit_seen    (hit_r),
    .fail_window (fail_window_r),
    .ent_out     (head_upd),
    .st          (est)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign time_ok     = in_ch.now_seconds > min_valid_r;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign shift       = (state_r == ST_WALK) && (!est.emit || out_free);

  // sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    step_nxt      = step_r;
    used_nxt      = used_r;
    hit_nxt       = hit_r;
    nrec_nxt      = nrec_r;
    news_nxt      = news_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ev_nxt    = out_ev_r;
    out_key_nxt   = out_key_r;
    out_rec_nxt   = out_rec_r;
    out_news_nxt  = out_news_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && time_ok) begin
          op_nxt.kind = in_ch.kind;
          op_nxt.key  = in_ch.source_key;
          op_nxt.ok   = in_ch.success;
          op_nxt.now  = in_ch.now_seconds;
          step_nxt    = '0;
          hit_nxt     = 1'b0;
          nrec_nxt    = '0;
          news_nxt    = 1'b0;
          state_nxt   = ST_WALK;
        end
      end
      ST_WALK: begin
        if (shift) begin
          if (est.hit) hit_nxt = 1'b1;
          if (est.fresh) used_nxt = used_r + CNT_W'(1);
          if (est.recover) begin
            nrec_nxt = nrec_r + REC_W'(1);
            news_nxt = 1'b1;
          end
          if (est.emit) begin
            news_nxt      = 1'b1;
            out_valid_nxt = 1'b1;
            out_ev_nxt    = EV_DOWN;
            out_key_nxt   = ring[0].key;
            out_rec_nxt   = '0;
            out_news_nxt  = 1'b0;
            out_last_nxt  = 1'b0;
          end
          step_nxt = step_r + CNT_W'(1);
          if (step_r == CNT_W'(ENTRIES - 1)) begin
            state_nxt = (op_r.kind == KIND_SCAN) ? ST_SUM : ST_IDLE;
          end
        end
      end
      ST_SUM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = EV_SUMMARY;
          out_key_nxt   = '0;
          out_rec_nxt   = nrec_r;
          out_news_nxt  = news_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    step_r     <= step_nxt;
    hit_r      <= hit_nxt;
    nrec_r     <= nrec_nxt;
    news_r     <= news_nxt;
    out_ev_r   <= out_ev_nxt;
    out_key_r  <= out_key_nxt;
    out_rec_r  <= out_rec_nxt;
    out_news_r <= out_news_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.event_res       = out_ev_r;
  assign out_ch.down_key        = out_key_r;
  assign out_ch.recovered_count = out_rec_r;
  assign out_ch.any_news        = out_news_r;
  assign out_ch.last            = out_last_r;

  // fill count never passes the table size
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(ENTRIES))
    else $error("fill count above table size");

  // fill count never shrinks
  a_used_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> used_r >= $past(used_r))
    else $error("fill count decreased");

  // summary leaves as the final result of a scan
  a_sum_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) && out_free |=> out_ch.valid && out_ch.last &&
      (out_ch.event_res == EV_SUMMARY) && (state_r == ST_IDLE))
    else $error("summary not issued");

  // a down result never carries the last mark
  a_down_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.event_res == EV_DOWN) |-> !out_ch.last)
    else $error("down result marked last");
endmodule

[dv/source_liveness_watch_table_test.sv]
// Self-checking bench for source_liveness_watch_table: directed and random
// report/scan requests, with a shadow liveness table predicting every alert.
// Depends on slwt_pkg, slwt_ifs and the RTL of the block.
module source_liveness_watch_table_test;
  import slwt_pkg::*;

  localparam int      CYCLE_LIMIT   = 600000;
  localparam int      SETTLE_CYCLES = 3 * ENTRIES + 8;
  localparam int      HOLD_CYCLES   = 800;
  localparam longint  TIME_TOP      = 64'h0000_0000_FFFF_FFFF;

  // one result as seen on the output channel
  typedef struct packed {
    logic              event_res;
    logic [KEY_W-1:0]  down_key;
    logic [REC_W-1:0]  recovered_count;
    logic              any_news;
    logic              last;
  } alert_t;

  logic clk;
  logic rst_n;

  slwt_in_if  in_ch();
  slwt_out_if out_ch();
  slwt_cfg_if cfg_ch();

  source_liveness_watch_table u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // request stream and expected alerts
  op_t               req_backlog[$];
  alert_t            alerts_due[$];
  logic [KEY_W-1:0]  table_keys[$];

  // shadow of the liveness table and its registers
  logic [KEY_W-1:0]  sh_key[ENTRIES];
  logic [TIME_W-1:0] sh_ok_t[ENTRIES];
  logic [TIME_W-1:0] sh_try_t[ENTRIES];
  bit                sh_flag[ENTRIES];
  int                sh_used;
  logic [WIN_W-1:0]  sh_window;
  logic [TIME_W-1:0] sh_min_valid;

  // register values as the stimulus side last wrote them
  logic [TIME_W-1:0] gen_min = MIN_VALID_RST;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_arm = 0;
  bit   hold_spent;
  int   hold_left;
  bit   in_fire;
  int   fault_count = 0;
  int   cycle_count = 0;
  op_t  next_req;
  op_t  seen_req;
  alert_t seen_alert;
  alert_t due_alert;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic alert_t make_alert(logic ev, logic [KEY_W-1:0] key,
                                        logic [REC_W-1:0] rec, logic news,
                                        logic fin);
    alert_t a;
    a.event_res       = ev;
    a.down_key        = key;
    a.recovered_count = rec;
    a.any_news        = news;
    a.last            = fin;
    return a;
  endfunction

  // apply one accepted request to the shadow table, queue the alerts it causes
  function automatic void shadow_table_step(input op_t req);
    int     i;
    int     slot;
    int     n_down;
    int     n_rec;
    longint t_now;
    longint t_seen;
    longint since_try;
    longint since_ok;
    longint win;
    bit     is_down;
    bit     recent;
    if (req.now <= sh_min_valid) return;
    if (req.kind == KIND_REPORT) begin
      slot = -1;
      for (i = 0; i < sh_used; i++) begin
        if (sh_key[i] == req.key) begin
          slot = i;
          break;
        end
      end
      // first contact while there is room
      if (slot < 0 && sh_used < ENTRIES) begin
        slot = sh_used;
        sh_used++;
        sh_key[slot]  = req.key;
        sh_ok_t[slot] = req.now;
        sh_flag[slot] = 1'b0;
      end
      if (slot >= 0) begin
        sh_try_t[slot] = req.now;
        if (req.ok) begin
          sh_ok_t[slot] = req.now;
          sh_flag[slot] = 1'b0;
        end
      end
      return;
    end
    // scan: signed time differences against the window
    n_down = 0;
    n_rec  = 0;
    t_now  = req.now;
    win    = sh_window;
    for (i = 0; i < sh_used; i++) begin
      t_seen    = sh_try_t[i];
      since_try = t_now - t_seen;
      t_seen    = sh_ok_t[i];
      since_ok  = t_now - t_seen;
      recent    = since_try < win;
      is_down   = since_ok > win;
      if (is_down && recent && !sh_flag[i]) begin
        alerts_due.push_back(make_alert(EV_DOWN, sh_key[i], '0, 1'b0, 1'b0));
        sh_flag[i] = 1'b1;
        n_down++;
      end else if (!is_down && sh_flag[i]) begin
        sh_flag[i] = 1'b0;
        n_rec++;
      end
    end
    alerts_due.push_back(make_alert(EV_SUMMARY, '0, REC_W'(n_rec),
                                    (n_down > 0 || n_rec > 0), 1'b1));
  endfunction

  // monitor: check results, predict on accepted requests, track registers
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire      = 1'b0;
      sh_used      = 0;
      sh_window    = FAIL_WINDOW_RST;
      sh_min_valid = MIN_VALID_RST;
      alerts_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen_alert = make_alert(out_ch.event_res, out_ch.down_key,
                                out_ch.recovered_count, out_ch.any_news, out_ch.last);
        if (alerts_due.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected result: ev=%0d key=%h rec=%0d news=%0d last=%0d",
                     seen_alert.event_res, seen_alert.down_key,
                     seen_alert.recovered_count, seen_alert.any_news, seen_alert.last);
        end else begin
          due_alert = alerts_due.pop_front();
          if (seen_alert.event_res !== due_alert.event_res ||
              seen_alert.down_key !== due_alert.down_key ||
              seen_alert.recovered_count !== due_alert.recovered_count ||
              seen_alert.any_news !== due_alert.any_news ||
              seen_alert.last !== due_alert.last) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("mismatch: got  ev=%0d key=%h rec=%0d news=%0d last=%0d",
                       seen_alert.event_res, seen_alert.down_key,
                       seen_alert.recovered_count, seen_alert.any_news, seen_alert.last);
              $display("          want ev=%0d key=%h rec=%0d news=%0d last=%0d",
                       due_alert.event_res, due_alert.down_key,
                       due_alert.recovered_count, due_alert.any_news, due_alert.last);
            end
          end
        end
      end
      in_fire = in_ch.valid && in_ch.ready;
      if (in_fire) begin
        seen_req.kind = in_ch.kind;
        seen_req.key  = in_ch.source_key;
        seen_req.ok   = in_ch.success;
        seen_req.now  = in_ch.now_seconds;
        shadow_table_step(seen_req);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_FAIL_WINDOW)
          sh_window = cfg_ch.data[WIN_W-1:0];
        else
          sh_min_valid = cfg_ch.data;
      end
    end
  end

  // driver: next request from the backlog, with random idle cycles
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = req_backlog.pop_front();
        in_ch.kind        <= next_req.kind;
        in_ch.source_key  <= next_req.key;
        in_ch.success     <= next_req.ok;
        in_ch.now_seconds <= next_req.now;
        in_ch.valid       <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side: random stalls, plus the long hold-off
  always @(negedge clk) begin
    if (!rst_n)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off, counted here once armed
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      hold_spent <= 1'b0;
    end else if (hold_arm && !hold_spent) begin
      hold_left  <= HOLD_CYCLES;
      hold_spent <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("source_liveness_watch_table_test: done, errors");
      $finish;
    end
  end

  task automatic queue_req(input logic kind, input logic [KEY_W-1:0] key,
                           input logic ok, input logic [TIME_W-1:0] now);
    op_t req;
    req.kind = kind;
    req.key  = key;
    req.ok   = ok;
    req.now  = now;
    req_backlog.push_back(req);
  endtask

  // wait until every request is taken and every alert has come, then let
  // a report still in the ring finish; go again if a request slipped in
  task automatic settle();
    do begin
      @(negedge clk);
      while (req_backlog.size() != 0 || (in_ch.valid && !in_fire) ||
             alerts_due.size() != 0)
        @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
    end while (req_backlog.size() != 0 || in_ch.valid || alerts_due.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_MIN_VALID) gen_min = val;
  endtask

  // random requests: time drifts forward, sometimes jumps back; now and then
  // every known source fails at once and a scan follows
  task automatic queue_random_phase(input longint t_first, input int step_max,
                                    input int n_req, input bit count_ignored);
    longint t;
    int     taken;
    int     k;
    bit     fresh;
    op_t    req;
    t = t_first;
    taken = 0;
    while (taken < n_req) begin
      if ($urandom_range(99) < 6) begin
        t = t - $urandom_range(2 * step_max + 10);
        if (t < 0) t = 0;
      end else begin
        t = t + $urandom_range(step_max);
        if (t > TIME_TOP) t = TIME_TOP;
      end
      if (!count_ignored && $urandom_range(99) < 4) begin
        for (k = 0; k < table_keys.size(); k++)
          queue_req(KIND_REPORT, table_keys[k], 1'b0, t[31:0]);
        queue_req(KIND_SCAN, {$urandom, $urandom}, 1'($urandom), t[31:0]);
        taken += table_keys.size() + 1;
      end
      req.now = t[31:0];
      if (count_ignored)
        req.now = $urandom;
      else if ($urandom_range(99) < 5)
        req.now = $urandom_range(gen_min);
      req.kind = ($urandom_range(99) < 25) ? KIND_SCAN : KIND_REPORT;
      req.ok   = ($urandom_range(99) < 30);
      fresh = 1'b0;
      if (req.kind == KIND_SCAN) begin
        req.key = {$urandom, $urandom};
      end else if ($urandom_range(99) < 5) begin
        // unknown source, dropped while the table is full
        req.key = {$urandom, $urandom};
        fresh = 1'b1;
      end else begin
        req.key = table_keys[$urandom_range(table_keys.size() - 1)];
      end
      req_backlog.push_back(req);
      if (count_ignored || !(req.now <= gen_min || fresh)) taken++;
    end
  endtask

  task automatic run_phase(input int window, input logic [TIME_W-1:0] min_valid,
                           input int send_pct, input int recv_pct, input bit with_hold,
                           input longint t_first, input int step_max, input int n_req,
                           input bit count_ignored);
    settle();
    write_reg(CFG_FAIL_WINDOW, CFG_W'(window));
    write_reg(CFG_MIN_VALID, min_valid);
    if (with_hold) hold_arm = 1'b1;
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random_phase(t_first, step_max, n_req, count_ignored);
  endtask

  initial begin
    logic [TIME_W-1:0] t0;
    logic [KEY_W-1:0]  k;
    int                i;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_REPORT;
    in_ch.source_key  = '0;
    in_ch.success     = 1'b0;
    in_ch.now_seconds = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_FAIL_WINDOW;
    cfg_ch.data       = '0;
    rst_n             = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part on the reset register values
    @(posedge clk);
    t0 = MIN_VALID_RST + 1;
    queue_req(KIND_SCAN, 64'hDEAD_BEEF_0000_0001, 1'b1, MIN_VALID_RST);   // time not valid
    queue_req(KIND_REPORT, 64'h0123_4567_89AB_CDEF, 1'b0, MIN_VALID_RST); // ignored
    queue_req(KIND_SCAN, '0, 1'b0, t0);                                   // empty table
    queue_req(KIND_REPORT, '0, 1'b1, t0);
    queue_req(KIND_REPORT, '1, 1'b0, t0);
    queue_req(KIND_REPORT, '1, 1'b0, t0 + 3700);
    queue_req(KIND_SCAN, '0, 1'b0, t0 + 3700);                            // all-ones goes down
    queue_req(KIND_SCAN, '1, 1'b1, t0 + 100);                             // time back: recovers
    queue_req(KIND_REPORT, '1, 1'b0, t0 + 7400);
    queue_req(KIND_SCAN, '0, 1'b0, t0 + 7400);                            // down again
    queue_req(KIND_REPORT, '1, 1'b1, t0 + 7401);                          // success clears flag
    table_keys.push_back('0);
    table_keys.push_back('1);
    // fill the table, then one source too many
    for (i = 0; i < ENTRIES - 2; i++) begin
      k = {$urandom, $urandom};
      table_keys.push_back(k);
      queue_req(KIND_REPORT, k, 1'b0, t0 + 7500);
    end
    queue_req(KIND_REPORT, 64'h5A5A_A5A5_0F0F_F0F0, 1'b0, t0 + 7500);

    // random phases over the register settings and idle patterns
    run_phase(120, 32'd1700000000, 0, 0, 1'b0, 64'd1699999950, 40, 65, 1'b0);
    run_phase(1, 32'd0, 64, 0, 1'b0, 64'd0, 1, 55, 1'b0);
    run_phase(86400, 32'hFF00_0000, 0, 64, 1'b0, 64'hFF00_0001, 30000, 55, 1'b0);
    run_phase(0, 32'd12345, 25, 25, 1'b0, 64'd12000, 5, 45, 1'b0);
    run_phase(300, 32'd5000, 0, 0, 1'b1, 64'd6000, 100, 55, 1'b0);
    // every time invalid: nothing may come out
    run_phase(7, 32'hFFFF_FFFF, 25, 25, 1'b0, 64'd0, 1, 12, 1'b1);
    queue_req(KIND_SCAN, '1, 1'b1, 32'hFFFF_FFFF);
    run_phase(3600, 32'd1000, 25, 25, 1'b0, 64'd2000, 1200, 55, 1'b0);

    settle();
    if (fault_count == 0 && alerts_due.size() == 0) begin
      $display("source_liveness_watch_table_test: done, clean");
    end else begin
      $display("source_liveness_watch_table_test: done, errors");
    end
    $finish;
  end

endmodule
